// ===== rtl/load_weighted_slot_scheduler_top_assert.svh =====
// Assertion macros for the load-weighted slot scheduler.
`ifndef LOAD_WEIGHTED_SLOT_SCHEDULER_TOP_ASSERT_SVH
`define LOAD_WEIGHTED_SLOT_SCHEDULER_TOP_ASSERT_SVH
// Implication checked on every clock, muted in reset.
`define LWSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define LWSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/lwss_pkg.sv =====
// ----------------------------------------------------------------------------
// lwss_pkg
// Shared types and constants of the load-weighted slot scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lwss_pkg;
    localparam int COUNT_WIDTH   = 16;
    localparam int NUM_MC        = 4;
    localparam int DEFAULT_SLOT  = 5;
    localparam int WINDOW_TOTAL  = 5 * NUM_MC;
    localparam logic [3:0] MASK_PAIR_A = 4'd9;
    localparam logic [3:0] MASK_PAIR_B = 4'd6;
    localparam logic [15:0] PERIOD_RESET = 16'd1000;
    localparam int ADDR_COMPUTE_PERIOD = 0;

    typedef struct packed {
        logic [15:0] req_count_3;
        logic [15:0] req_count_2;
        logic [15:0] req_count_1;
        logic [15:0] req_count_0;
        logic [15:0] queue_depth_3;
        logic [15:0] queue_depth_2;
        logic [15:0] queue_depth_1;
        logic [15:0] queue_depth_0;
    } in_word_t;

    typedef struct packed {
        logic [4:0] slot_len_3;
        logic [4:0] slot_len_2;
        logic [4:0] slot_len_1;
        logic [4:0] slot_len_0;
        logic       clear_req_counts;
        logic [3:0] send_enable_mask;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQRT_D_LOAD, ST_SQRT_D, ST_SQRT_R_LOAD, ST_SQRT_R, ST_CHECK_NORM,
        ST_DIV_LOAD, ST_DIV_RUN, ST_MIN, ST_RATIO_LOAD, ST_RATIO_RUN, ST_SLOT_LOAD,
        ST_SLOT_RUN, ST_OUT
    } state_t;

    // Shared divider request/response.
    typedef struct packed {
        logic        start;
        logic [33:0] num;
        logic [33:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [33:0] quo;
    } div_rsp_t;
endpackage

// ===== rtl/lwss_isqrt.sv =====
// ----------------------------------------------------------------------------
// lwss_isqrt
// Bit-pair restoring square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lwss_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [33:0] radicand,
    output logic        done,
    output logic [16:0] root
);
    logic [33:0] rad_reg, rad_next;
    logic [18:0] rem_reg, rem_next;
    logic [16:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [18:0] shifted, trial;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[16:0], rad_reg[33:32]};
        trial     = {root_reg, 2'b01};
        done      = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[31:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd16)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_next;
endmodule

// ===== rtl/lwss_divider.sv =====
// ----------------------------------------------------------------------------
// lwss_divider
// Shared restoring divider, 34-bit operands, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lwss_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  lwss_pkg::div_req_t req,
    output lwss_pkg::div_rsp_t rsp
);
    logic [33:0] num_reg, num_next;
    logic [33:0] den_reg, den_next;
    logic [34:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [34:0] sh;

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        sh        = {rem_reg[33:0], num_reg[33]};
        rsp.done  = 1'b0;
        if (req.start)
        begin
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // quotient bits shift into num_reg as dividend bits leave
            if (sh >= {1'b0, den_reg})
            begin
                rem_next = sh - {1'b0, den_reg};
                num_next = {num_reg[32:0], 1'b1};
            end
            else
            begin
                rem_next = sh;
                num_next = {num_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd33)
            begin
                busy_next = 1'b0;
                rsp.done  = 1'b1;
            end
        end
        rsp.quo = num_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end
endmodule

// ===== rtl/load_weighted_slot_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// load_weighted_slot_scheduler_top
// Tick-driven slot scheduler for four memory controllers.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one tick word (four queue depths, four request
//   counts). out_valid/out_ready carry one result word per tick: the enable
//   mask, the clear flag and the four slot lengths after that tick.
//   An APB-style port writes compute_period at address 0.
// Flow:
//   A tick without recompute shows its result word the cycle after accept;
//   the next tick is taken the cycle after that word leaves. One tick is
//   in flight at a time.
//   A recompute tick runs two 17-step square roots, then sixteen 34-step
//   divisions (eight normalizations, four ratios, four slot shares) on the
//   shared divider, each after its own load state, before the word shows. A
//   zero norm ends after the roots, a zero minimum after the normalizations.
// Reset:
//   period counter, window timer and enables clear; slots return to 5;
//   compute_period returns to 1000.
// Stall:
//   while out_valid waits on out_ready the word holds and no tick is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "load_weighted_slot_scheduler_top_assert.svh"
module load_weighted_slot_scheduler_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lwss_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lwss_pkg::out_word_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    lwss_pkg::state_t state_reg, state_next;

    logic [15:0] period_reg, period_next;
    logic [15:0] pcnt_reg, pcnt_next;
    logic [4:0]  timer_reg, timer_next;
    logic [3:0]  en_reg, en_next;
    logic [4:0]  slot_reg [4];
    logic [4:0]  slot_next [4];
    logic        clr_reg, clr_next;
    logic        ov_reg, ov_next;

    // recompute working registers
    logic [15:0] dep_reg [4];
    logic [15:0] req_reg [4];
    logic [16:0] nd_reg, nd_next, nr_reg, nr_next;
    logic [33:0] val_reg [4];   // scores, then ratios, then slot shares
    logic [33:0] val_next [4];
    logic [33:0] min_reg, min_next;
    logic [33:0] sum_reg, sum_next;
    logic [2:0]  idx_reg, idx_next;  // division index 0..7 for normalize

    logic [33:0] sq_sum;
    logic        sq_start;
    logic        sq_done;
    logic [16:0] sq_root;
    lwss_pkg::div_req_t dreq;
    lwss_pkg::div_rsp_t drsp;

    logic cfg_wr;
    logic in_acc;
    logic out_acc;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata  = (paddr[2] == 1'b0) ? {16'd0, period_reg} : 32'd0;
    assign in_ready = (state_reg == lwss_pkg::ST_IDLE) && !ov_reg;
    assign in_acc   = in_valid && in_ready;
    assign out_acc  = ov_reg && out_ready;
    assign out_valid = ov_reg;
    assign out_data = '{slot_len_3: slot_reg[3], slot_len_2: slot_reg[2],
                        slot_len_1: slot_reg[1], slot_len_0: slot_reg[0],
                        clear_req_counts: clr_reg, send_enable_mask: en_reg};

    // square root operand: sum of squares of depths or of requests
    always_comb
    begin
        sq_sum = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (state_reg == lwss_pkg::ST_SQRT_D_LOAD)
                sq_sum = sq_sum + 34'(dep_reg[k]) * 34'(dep_reg[k]);
            else
                sq_sum = sq_sum + 34'(req_reg[k]) * 34'(req_reg[k]);
        end
    end

    lwss_isqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_sum),
        .done     (sq_done),
        .root     (sq_root)
    );

    lwss_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        state_next = state_reg;
        period_next = cfg_wr ? pwdata[15:0] : period_reg;
        pcnt_next  = pcnt_reg;
        timer_next = timer_reg;
        en_next    = en_reg;
        clr_next   = clr_reg;
        ov_next    = ov_reg;
        nd_next    = nd_reg;
        nr_next    = nr_reg;
        min_next   = min_reg;
        sum_next   = sum_reg;
        idx_next   = idx_reg;
        sq_start   = 1'b0;
        dreq       = '0;
        for (int k = 0; k < 4; k++)
        begin
            slot_next[k] = slot_reg[k];
            val_next[k]  = val_reg[k];
        end
        if (out_acc)
            ov_next = 1'b0;

        case (state_reg)
            lwss_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    // window timer runs on the slots held at tick start
                    if (timer_reg < 5'(lwss_pkg::WINDOW_TOTAL))
                    begin
                        if (timer_reg < slot_reg[0])
                            en_next = lwss_pkg::MASK_PAIR_A;
                        else if (6'(timer_reg) < 6'(slot_reg[0]) + 6'(slot_reg[1]))
                            en_next = lwss_pkg::MASK_PAIR_B;
                        else if (7'(timer_reg) < 7'(slot_reg[0]) + 7'(slot_reg[1])
                                 + 7'(slot_reg[2]))
                            en_next = lwss_pkg::MASK_PAIR_A;
                        else
                            en_next = lwss_pkg::MASK_PAIR_B;
                        timer_next = timer_reg + 5'd1;
                    end
                    else
                        timer_next = '0;
                    clr_next = 1'b0;
                    if (pcnt_reg >= period_reg)
                    begin
                        pcnt_next  = 16'd1;
                        state_next = lwss_pkg::ST_SQRT_D_LOAD;
                    end
                    else
                    begin
                        pcnt_next = pcnt_reg + 16'd1;
                        ov_next   = 1'b1;
                    end
                end
            end
            lwss_pkg::ST_SQRT_D_LOAD:
            begin
                // depths are captured now; start the root of their squares
                sq_start   = 1'b1;
                state_next = lwss_pkg::ST_SQRT_D;
            end
            lwss_pkg::ST_SQRT_D:
            begin
                if (sq_done)
                begin
                    nd_next    = sq_root;
                    state_next = lwss_pkg::ST_SQRT_R_LOAD;
                end
            end
            lwss_pkg::ST_SQRT_R_LOAD:
            begin
                sq_start   = 1'b1;
                state_next = lwss_pkg::ST_SQRT_R;
            end
            lwss_pkg::ST_SQRT_R:
            begin
                if (sq_done)
                begin
                    nr_next    = sq_root;
                    state_next = lwss_pkg::ST_CHECK_NORM;
                end
            end
            lwss_pkg::ST_CHECK_NORM:
            begin
                idx_next = '0;
                for (int k = 0; k < 4; k++)
                    val_next[k] = '0;
                if (nd_reg == '0 || nr_reg == '0)
                    state_next = lwss_pkg::ST_OUT;
                else
                    state_next = lwss_pkg::ST_DIV_LOAD;
            end
            lwss_pkg::ST_DIV_LOAD:
            begin
                dreq.start = 1'b1;
                if (idx_reg[2])
                begin
                    dreq.num = {2'b00, req_reg[idx_reg[1:0]], 16'd0};
                    dreq.den = {17'd0, nr_reg};
                end
                else
                begin
                    dreq.num = {2'b00, dep_reg[idx_reg[1:0]], 16'd0};
                    dreq.den = {17'd0, nd_reg};
                end
                state_next = lwss_pkg::ST_DIV_RUN;
            end
            lwss_pkg::ST_DIV_RUN:
            begin
                if (drsp.done)
                begin
                    // accumulate the score: depth share once, request share four times
                    if (idx_reg[2])
                        val_next[idx_reg[1:0]] = val_reg[idx_reg[1:0]]
                                                 + {drsp.quo[31:0], 2'b00};
                    else
                        val_next[idx_reg[1:0]] = val_reg[idx_reg[1:0]] + drsp.quo;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        idx_next   = '0;
                        state_next = lwss_pkg::ST_MIN;
                    end
                    else
                        state_next = lwss_pkg::ST_DIV_LOAD;
                end
            end
            lwss_pkg::ST_MIN:
            begin
                // walk the four scores one a cycle
                if (idx_reg == '0 || val_reg[idx_reg[1:0]] < min_reg)
                    min_next = val_reg[idx_reg[1:0]];
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd3)
                begin
                    idx_next = '0;
                    sum_next = '0;
                    state_next = lwss_pkg::ST_RATIO_LOAD;
                end
            end
            lwss_pkg::ST_RATIO_LOAD:
            begin
                if (min_reg == '0)
                    state_next = lwss_pkg::ST_OUT;
                else
                begin
                    dreq.start = 1'b1;
                    dreq.num   = val_reg[idx_reg[1:0]];
                    dreq.den   = min_reg;
                    state_next = lwss_pkg::ST_RATIO_RUN;
                end
            end
            lwss_pkg::ST_RATIO_RUN:
            begin
                if (drsp.done)
                begin
                    val_next[idx_reg[1:0]] = drsp.quo;
                    sum_next = sum_reg + drsp.quo;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd3)
                    begin
                        idx_next   = '0;
                        state_next = lwss_pkg::ST_SLOT_LOAD;
                    end
                    else
                        state_next = lwss_pkg::ST_RATIO_LOAD;
                end
            end
            lwss_pkg::ST_SLOT_LOAD:
            begin
                // scores stay below 2^19, so ratios do too and 20*ratio fits
                dreq.start = 1'b1;
                dreq.num   = 34'({val_reg[idx_reg[1:0]][29:0], 4'b0000}
                                 + {val_reg[idx_reg[1:0]][31:0], 2'b00});
                dreq.den   = sum_reg;
                state_next = lwss_pkg::ST_SLOT_RUN;
            end
            lwss_pkg::ST_SLOT_RUN:
            begin
                if (drsp.done)
                begin
                    val_next[idx_reg[1:0]] = drsp.quo;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd3)
                    begin
                        for (int k = 0; k < 3; k++)
                            slot_next[k] = val_reg[k][4:0];
                        slot_next[3] = drsp.quo[4:0];
                        clr_next     = 1'b1;
                        ov_next      = 1'b1;
                        state_next   = lwss_pkg::ST_IDLE;
                    end
                    else
                        state_next = lwss_pkg::ST_SLOT_LOAD;
                end
            end
            lwss_pkg::ST_OUT:
            begin
                // failed recompute: restore default slots
                for (int k = 0; k < 4; k++)
                    slot_next[k] = 5'(lwss_pkg::DEFAULT_SLOT);
                ov_next    = 1'b1;
                state_next = lwss_pkg::ST_IDLE;
            end
            default:
                state_next = lwss_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lwss_pkg::ST_IDLE;
            period_reg <= lwss_pkg::PERIOD_RESET;
            pcnt_reg   <= '0;
            timer_reg  <= '0;
            en_reg     <= '0;
            clr_reg    <= 1'b0;
            ov_reg     <= 1'b0;
            idx_reg    <= '0;
            for (int k = 0; k < 4; k++)
                slot_reg[k] <= 5'(lwss_pkg::DEFAULT_SLOT);
        end
        else
        begin
            state_reg  <= state_next;
            period_reg <= period_next;
            pcnt_reg   <= pcnt_next;
            timer_reg  <= timer_next;
            en_reg     <= en_next;
            clr_reg    <= clr_next;
            ov_reg     <= ov_next;
            idx_reg    <= idx_next;
            for (int k = 0; k < 4; k++)
                slot_reg[k] <= slot_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        nd_reg  <= nd_next;
        nr_reg  <= nr_next;
        min_reg <= min_next;
        sum_reg <= sum_next;
        for (int k = 0; k < 4; k++)
            val_reg[k] <= val_next[k];
        if (in_acc)
        begin
            dep_reg[0] <= in_data.queue_depth_0;
            dep_reg[1] <= in_data.queue_depth_1;
            dep_reg[2] <= in_data.queue_depth_2;
            dep_reg[3] <= in_data.queue_depth_3;
            req_reg[0] <= in_data.req_count_0;
            req_reg[1] <= in_data.req_count_1;
            req_reg[2] <= in_data.req_count_2;
            req_reg[3] <= in_data.req_count_3;
        end
    end

    `LWSS_ASSERT_IMP(a_busy_not_ready, clk, rst_n,
        state_reg != lwss_pkg::ST_IDLE, !in_ready, "tick taken while recomputing")
    `LWSS_ASSERT_NXT(a_out_holds, clk, rst_n,
        out_valid && !out_ready, out_valid && $stable(out_data), "result word dropped")
    `LWSS_ASSERT_IMP(a_clear_slots, clk, rst_n,
        out_valid && out_data.clear_req_counts,
        (7'(out_data.slot_len_0) + 7'(out_data.slot_len_1) + 7'(out_data.slot_len_2)
         + 7'(out_data.slot_len_3)) <= 7'd20, "slot sum exceeds window")
endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the load-weighted slot scheduler: ticks are driven
// over valid/ready, a cycle-free predictor tracks period counter, window
// timer and slot lengths, and every result word is compared as a whole.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    lwss_pkg::in_word_t  in_data;
    logic                out_valid;
    logic                out_ready;
    lwss_pkg::out_word_t out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    load_weighted_slot_scheduler_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor copy of the block's state and register.
    logic [15:0] period_reg;
    logic [15:0] tick_count;
    logic [4:0]  slot_q [lwss_pkg::NUM_MC];
    logic [4:0]  win_timer;
    logic [3:0]  enables;

    // Queues take new entries at the front and hand out the oldest at the back.
    lwss_pkg::in_word_t  tick_queue[$];
    lwss_pkg::out_word_t expected_words[$];
    int        fail_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        sent_count;
    int        accepted_count;
    bit        hold_send;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Integer square root of the sum of squares, exact on a 66-bit sum.
    function automatic logic [33:0] euclid_norm(input logic [15:0] v [lwss_pkg::NUM_MC]);
        logic [65:0] acc;
        logic [67:0] rem;
        logic [35:0] root;
        logic [67:0] trial;
        acc = '0;
        rem = '0;
        root = '0;
        for (int k = 0; k < lwss_pkg::NUM_MC; k++)
            acc += 66'(v[k]) * 66'(v[k]);
        for (int k = 32; k >= 0; k--)
        begin
            rem = (rem << 2) | 68'(acc[2*k +: 2]);
            trial = 68'({root, 2'b01});
            if (rem >= trial)
            begin
                rem -= trial;
                root = {root[34:0], 1'b1};
            end
            else
                root = {root[34:0], 1'b0};
        end
        return root[33:0];
    endfunction

    // Advance the predictor by one tick and return the word it should show.
    function automatic lwss_pkg::out_word_t schedule_tick(input lwss_pkg::in_word_t w);
        logic [15:0] depth [lwss_pkg::NUM_MC];
        logic [15:0] reqs [lwss_pkg::NUM_MC];
        logic [63:0] score [lwss_pkg::NUM_MC];
        logic [63:0] ratio [lwss_pkg::NUM_MC];
        logic [63:0] nd, nr, minv, total;
        logic [5:0]  e1, e2, e3;
        logic        cleared;
        lwss_pkg::out_word_t r;
        depth = '{w.queue_depth_0, w.queue_depth_1, w.queue_depth_2, w.queue_depth_3};
        reqs  = '{w.req_count_0, w.req_count_1, w.req_count_2, w.req_count_3};
        cleared = 1'b0;
        // Walk the window with slot lengths held at the start of the tick.
        if (win_timer < lwss_pkg::WINDOW_TOTAL)
        begin
            e1 = 6'(slot_q[0]);
            e2 = e1 + 6'(slot_q[1]);
            e3 = e2 + 6'(slot_q[2]);
            if (6'(win_timer) < e1)      enables = lwss_pkg::MASK_PAIR_A;
            else if (6'(win_timer) < e2) enables = lwss_pkg::MASK_PAIR_B;
            else if (6'(win_timer) < e3) enables = lwss_pkg::MASK_PAIR_A;
            else                         enables = lwss_pkg::MASK_PAIR_B;
            win_timer = win_timer + 5'd1;
        end
        else
            win_timer = '0;
        if (tick_count >= period_reg)
        begin
            nd = 64'(euclid_norm(depth));
            nr = 64'(euclid_norm(reqs));
            if (nd != 0 && nr != 0)
            begin
                for (int i = 0; i < lwss_pkg::NUM_MC; i++)
                    score[i] = 4 * ((64'(reqs[i]) << 16) / nr)
                               + ((64'(depth[i]) << 16) / nd);
                minv = score[0];
                for (int i = 1; i < lwss_pkg::NUM_MC; i++)
                    if (score[i] < minv) minv = score[i];
                if (minv != 0)
                begin
                    total = 0;
                    for (int i = 0; i < lwss_pkg::NUM_MC; i++)
                    begin
                        ratio[i] = score[i] / minv;
                        total += ratio[i];
                    end
                    for (int i = 0; i < lwss_pkg::NUM_MC; i++)
                        slot_q[i] = 5'((64'(lwss_pkg::WINDOW_TOTAL) * ratio[i]) / total);
                    cleared = 1'b1;
                end
            end
            // Restore default slots on a degenerate load picture.
            if (!cleared)
                for (int i = 0; i < lwss_pkg::NUM_MC; i++)
                    slot_q[i] = 5'(lwss_pkg::DEFAULT_SLOT);
            tick_count = '0;
        end
        tick_count = tick_count + 16'd1;
        r.send_enable_mask = enables;
        r.clear_req_counts = cleared;
        r.slot_len_0 = slot_q[0];
        r.slot_len_1 = slot_q[1];
        r.slot_len_2 = slot_q[2];
        r.slot_len_3 = slot_q[3];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input lwss_pkg::out_word_t got,
                                   input lwss_pkg::out_word_t want);
        $display("tb: %s got mask %h clr %b slots %0d %0d %0d %0d, want mask %h clr %b slots %0d %0d %0d %0d at %0t",
                 what, got.send_enable_mask, got.clear_req_counts, got.slot_len_0,
                 got.slot_len_1, got.slot_len_2, got.slot_len_3, want.send_enable_mask,
                 want.clear_req_counts, want.slot_len_0, want.slot_len_1, want.slot_len_2,
                 want.slot_len_3, $realtime);
        fail_count++;
    endtask

    // Driver: present the next tick at the falling edge, hold until taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || accepted_count == sent_count)
            begin
                if (tick_queue.size() != 0 && !hold_send
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data <= tick_queue.pop_back();
                    in_valid <= 1'b1;
                    sent_count++;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on accepted ticks, check on accepted results.
    always @(posedge clk)
    begin
        lwss_pkg::out_word_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_words.push_front(schedule_tick(in_data));
                accepted_count++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word", out_data, '0);
                else
                begin
                    want = expected_words.pop_back();
                    if (out_data !== want)
                        report_mismatch("result word", out_data, want);
                end
            end
        end
    end

    // Wait until every queued tick is taken and every result has come back.
    task automatic drain();
        while (tick_queue.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write compute_period over the APB port while the block is idle.
    task automatic write_period(input logic [15:0] value);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * lwss_pkg::ADDR_COMPUTE_PERIOD);
        pwdata <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        period_reg = value;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic logic [15:0] rand_load();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random(input int n);
        lwss_pkg::in_word_t w;
        for (int i = 0; i < n; i++)
        begin
            w = lwss_pkg::in_word_t'({$urandom, $urandom, $urandom, $urandom});
            if ($urandom_range(3) == 0)
            begin
                w.queue_depth_0 = rand_load(); w.queue_depth_1 = rand_load();
                w.queue_depth_2 = rand_load(); w.queue_depth_3 = rand_load();
                w.req_count_0 = rand_load(); w.req_count_1 = rand_load();
                w.req_count_2 = rand_load(); w.req_count_3 = rand_load();
            end
            tick_queue.push_front(w);
        end
    endtask

    initial
    begin
        lwss_pkg::in_word_t w;
        rst_n = 1'b0;
        in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        fail_count = 0; hold_send = 1'b0; sent_count = 0; accepted_count = 0;
        send_idle_pct = 12; recv_idle_pct = 64;
        period_reg = lwss_pkg::PERIOD_RESET; tick_count = '0; win_timer = '0;
        enables = '0;
        for (int i = 0; i < lwss_pkg::NUM_MC; i++) slot_q[i] = 5'(lwss_pkg::DEFAULT_SLOT);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: recompute on every tick to hit the special cases.
        write_period(16'd0);
        w = '0; tick_queue.push_front(w);                  // zero norms
        w.queue_depth_0 = 16'hFFFF; w.queue_depth_1 = 16'hFFFF;
        w.queue_depth_2 = 16'hFFFF; w.queue_depth_3 = 16'hFFFF;
        w.req_count_0 = 16'hFFFF; w.req_count_1 = 16'hFFFF;
        w.req_count_2 = 16'hFFFF; w.req_count_3 = 16'hFFFF;
        tick_queue.push_front(w);                          // all maxed, equal
        w.req_count_2 = 16'd0; w.queue_depth_2 = 16'd0;
        tick_queue.push_front(w);                          // zero minimum
        w = '0; w.req_count_0 = 16'd1; w.queue_depth_0 = 16'd1;
        tick_queue.push_front(w);                          // one controller only
        w = '0;
        w.req_count_0 = 16'd100; w.req_count_1 = 16'd1;
        w.req_count_2 = 16'd1; w.req_count_3 = 16'd1;
        w.queue_depth_0 = 16'd1; w.queue_depth_1 = 16'd1;
        w.queue_depth_2 = 16'd1; w.queue_depth_3 = 16'd1;
        tick_queue.push_front(w);                          // skewed, short total
        w.req_count_0 = 16'd1; w.req_count_3 = 16'hFFFF;
        tick_queue.push_front(w);
        queue_random(14);
        drain();

        write_period(16'd1);
        queue_random(400);
        drain();

        // Hold the sender mid-stream until every result is back, then resume.
        queue_random(50);
        repeat (3000) @(posedge clk);
        hold_send = 1'b1;
        while (expected_words.size() != 0 || in_valid) @(posedge clk);
        repeat (5) @(posedge clk);
        hold_send = 1'b0;
        drain();

        send_idle_pct = 64; recv_idle_pct = 12;
        write_period(16'd7);
        queue_random(350);
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        write_period(16'hFFFF);
        queue_random(200);
        drain();
        write_period(16'd3);
        queue_random(230);
        drain();

        if (fail_count == 0)
            $display("load_weighted_slot_scheduler_top: match");
        else
            $display("load_weighted_slot_scheduler_top: mismatch");
        $finish;
    end

    // Watchdog: far above the slowest run (~1250 ticks).
    initial
    begin
        #(8 * 4000000);
        $display("load_weighted_slot_scheduler_top: mismatch");
        $finish;
    end
endmodule
